/* rtl/mwdds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwdds_pkg: shared types and constants of the waveform synthesiser
// Wave shape codes, register indices, controller commands and the fixed
// arithmetic constants of the phase and duty paths.
// ----------------------------------------------------------------------------
package mwdds_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxBits  = 4;
  localparam int unsigned CfgDataBits = 32;

  // Register indices
  localparam logic [CfgIdxBits-1:0] CfgEnable    = 4'd0;
  localparam logic [CfgIdxBits-1:0] CfgWaveShape = 4'd1;
  localparam logic [CfgIdxBits-1:0] CfgFreq      = 4'd2;
  localparam logic [CfgIdxBits-1:0] CfgAmplitude = 4'd3;

  // Field widths fixed by the interface
  localparam int unsigned ElapsedBits = 16;
  localparam int unsigned DutyBits    = 8;
  localparam int unsigned FreqBits    = 17;
  localparam int unsigned AmpBits     = 7;

  // Register reset values
  localparam logic [FreqBits-1:0] FreqReset = 17'd7040;
  localparam logic [AmpBits-1:0]  AmpReset  = 7'd100;

  // Arithmetic constants
  localparam logic [19:0]          UsPerSecond = 20'd1000000;
  localparam logic [21:0]          AmpDiv      = 22'd3276700;
  localparam logic [18:0]          RecipMult   = 19'd335554;  // floor(2^40 / AmpDiv)
  localparam int unsigned          RecipShift  = 40;
  localparam logic signed [15:0]   Q15Max      = 16'sd32767;
  localparam logic [DutyBits-1:0]  DutyMid     = 8'd128;
  localparam logic [DutyBits-1:0]  DutyMax     = 8'd255;

  typedef enum logic [1:0] {
    WaveSine     = 2'd0,
    WaveSquare   = 2'd1,
    WaveTriangle = 2'd2,
    WaveSawtooth = 2'd3
  } wave_shape_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch elapsed time of the accepted beat
    logic mul;       // form frequency x elapsed, load the divider
    logic div_step;  // four quotient bits
    logic acc;       // advance the phase
    logic wave;      // read sine ROM, form ramp product
    logic samp;      // form the Q1.15 sample
    logic scale;     // amplitude x |sample|
    logic recip;     // reciprocal estimate of the quotient
    logic corr;      // correct the quotient
    logic out_load;  // load the output register
    logic out_mid;   // load the midpoint instead of the computed duty
  } mwdds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } mwdds_status_t;

endpackage

/* rtl/mwdds_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwdds_if: handshake channels of the waveform synthesiser
// Tick input, duty output and configuration write channels.
// ----------------------------------------------------------------------------
interface mwdds_in_if;
  logic                                valid;
  logic                                ready;
  logic [mwdds_pkg::ElapsedBits-1:0]   elapsed_us;

  modport source (output valid, output elapsed_us, input ready);
  modport sink   (input valid, input elapsed_us, output ready);
endinterface

interface mwdds_out_if;
  logic                             valid;
  logic                             ready;
  logic [mwdds_pkg::DutyBits-1:0]   pwm_duty;

  modport source (output valid, output pwm_duty, input ready);
  modport sink   (input valid, input pwm_duty, output ready);
endinterface

interface mwdds_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mwdds_pkg::CfgIdxBits-1:0]    idx;
  logic [mwdds_pkg::CfgDataBits-1:0]   data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

/* rtl/mwdds_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwdds_ctrl: sequencing controller
// Steps one tick through the datapath and owns the output valid flag.
// ----------------------------------------------------------------------------
module mwdds_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  logic                     enable_i,
  input  mwdds_pkg::mwdds_status_t status_i,
  output mwdds_pkg::mwdds_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    StIdle  = 11'b000_0000_0001,
    StMul   = 11'b000_0000_0010,
    StDiv   = 11'b000_0000_0100,
    StAcc   = 11'b000_0000_1000,
    StWave  = 11'b000_0001_0000,
    StSamp  = 11'b000_0010_0000,
    StScale = 11'b000_0100_0000,
    StRecip = 11'b000_1000_0000,
    StCorr  = 11'b001_0000_0000,
    StOut   = 11'b010_0000_0000,
    StMid   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = enable_i ? StMul : StMid;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = StWave;
      end
      StWave: begin
        cmd_o.wave = 1'b1;
        state_d    = StSamp;
      end
      StSamp: begin
        cmd_o.samp = 1'b1;
        state_d    = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StRecip;
      end
      StRecip: begin
        cmd_o.recip = 1'b1;
        state_d     = StCorr;
      end
      StCorr: begin
        cmd_o.corr = 1'b1;
        state_d    = StOut;
      end
      StOut: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      StMid: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_mid  = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/mwdds_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwdds_datapath: phase, wave and duty arithmetic
// Radix-16 divider for the phase step, phase accumulator, sine ROM, ramp
// shapes and the reciprocal scaler for the PWM duty.
// ----------------------------------------------------------------------------
module mwdds_datapath #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned PHASE_BITS         = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mwdds_pkg::mwdds_cmd_t               cmd_i,
  output mwdds_pkg::mwdds_status_t            status_o,
  input  logic [mwdds_pkg::ElapsedBits-1:0]   elapsed_us_i,
  input  logic [mwdds_pkg::FreqBits-1:0]      freq_i,
  input  mwdds_pkg::wave_shape_e              shape_i,
  input  logic [mwdds_pkg::AmpBits-1:0]       amp_i,
  output logic [mwdds_pkg::DutyBits-1:0]      pwm_duty_o
);

  localparam int unsigned IdxBits    = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned QBits      = IdxBits - 2;
  localparam int unsigned AddrBits   = IdxBits - 1;
  localparam int unsigned QuarterLen = SINE_TABLE_ENTRIES / 4;
  localparam int unsigned ProdBits   = mwdds_pkg::FreqBits + mwdds_pkg::ElapsedBits;
  localparam int unsigned NumBits    = ProdBits + PHASE_BITS - 4;
  localparam int unsigned DivSteps   = (NumBits + 3) / 4;
  localparam int unsigned NumPadBits = DivSteps * 4;
  localparam int unsigned CntBits    = $clog2(DivSteps);

  localparam logic [16:0] TriScale  = 17'd131068;
  localparam logic [16:0] TriRise   = 17'd32767;
  localparam logic [16:0] TriFall   = 17'd98301;
  localparam logic [16:0] TriPeak   = 17'd65534;
  localparam logic [16:0] TriWrap   = 17'd131068;
  localparam logic [16:0] SawScale  = 17'd65534;
  localparam logic [16:0] SawOffset = 17'd32767;

  // Quarter-wave sine in Q1.15, worked in Q2.30, Taylor series to the x^13 term
  function automatic logic [14:0] quarter_sine(input int unsigned m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        s;
    x    = (64'(m) * 64'd1686629713) >> QBits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      return 15'd0;
    end
    s = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[14:0];
  endfunction

  // Constant quarter-wave table
  logic [14:0] quarter_rom [QuarterLen+1];

  for (genvar m = 0; m <= QuarterLen; m++) begin : g_rom
    localparam logic [14:0] RomVal = quarter_sine(m);
    assign quarter_rom[m] = RomVal;
  end

  // Registers
  logic [mwdds_pkg::ElapsedBits-1:0] elapsed_q;
  logic [NumPadBits-1:0]             num_q;
  logic [19:0]                       rem_q;
  logic [PHASE_BITS-1:0]             quot_q;
  logic [CntBits-1:0]                cnt_q;
  logic [PHASE_BITS-1:0]             phase_q;
  logic [14:0]                       rom_q;
  logic                              neg_q;
  logic [16:0]                       u_q;
  logic signed [15:0]                sample_q, sample_d;
  logic                              sign_q;
  logic [28:0]                       a_q;
  logic [7:0]                        qa0_q;
  logic [7:0]                        qa_q;
  logic                              nz_q;
  logic [mwdds_pkg::DutyBits-1:0]    duty_q, duty_d;

  // Divider step
  logic [ProdBits-1:0] freq_prod;
  logic [19:0]         rem_v;
  logic [20:0]         trial;
  logic [3:0]          qbits;

  assign freq_prod = ProdBits'(freq_i) * ProdBits'(elapsed_q);

  always_comb begin
    rem_v = rem_q;
    qbits = '0;
    trial = '0;
    for (int j = 0; j < 4; j++) begin
      trial = {rem_v, num_q[NumPadBits-1-j]};
      if (trial >= {1'b0, mwdds_pkg::UsPerSecond}) begin
        rem_v        = 20'(trial - {1'b0, mwdds_pkg::UsPerSecond});
        qbits[3-j]   = 1'b1;
      end else begin
        rem_v = trial[19:0];
      end
    end
  end

  assign status_o.div_last = (cnt_q == CntBits'(DivSteps - 1));

  // Phase as a 32-bit fraction
  logic [31:0] ph32;
  if (PHASE_BITS >= 32) begin : g_ph_down
    assign ph32 = phase_q[PHASE_BITS-1 -: 32];
  end else begin : g_ph_up
    assign ph32 = {phase_q, {(32 - PHASE_BITS){1'b0}}};
  end

  logic [IdxBits-1:0]  sine_idx;
  logic [1:0]          quad;
  logic [QBits-1:0]    mpos;
  logic [AddrBits-1:0] rom_addr;
  logic [16:0]         wave_k;
  logic [48:0]         wave_prod;

  assign sine_idx  = ph32[31 -: IdxBits];
  assign quad      = sine_idx[IdxBits-1 -: 2];
  assign mpos      = sine_idx[QBits-1:0];
  assign rom_addr  = quad[0] ? (AddrBits'(QuarterLen) - {1'b0, mpos}) : {1'b0, mpos};
  assign wave_k    = (shape_i == mwdds_pkg::WaveTriangle) ? TriScale : SawScale;
  assign wave_prod = 49'(ph32) * 49'(wave_k);

  // Sample formation
  logic signed [15:0] rom_s;
  assign rom_s = signed'({1'b0, rom_q});

  always_comb begin
    case (shape_i)
      mwdds_pkg::WaveSine: begin
        sample_d = neg_q ? -rom_s : rom_s;
      end
      mwdds_pkg::WaveSquare: begin
        sample_d = ((phase_q != '0) && !phase_q[PHASE_BITS-1]) ?
                   mwdds_pkg::Q15Max : -mwdds_pkg::Q15Max;
      end
      mwdds_pkg::WaveTriangle: begin
        if (u_q < TriRise) begin
          sample_d = signed'(u_q[15:0]);
        end else if (u_q < TriFall) begin
          sample_d = signed'(16'(TriPeak - u_q));
        end else begin
          sample_d = signed'(16'(u_q - TriWrap));
        end
      end
      default: begin
        sample_d = signed'(16'(u_q - SawOffset));
      end
    endcase
  end

  // Amplitude scaling and reciprocal division
  logic [14:0] mag;
  logic [13:0] amp127;
  logic [47:0] recip_prod;
  logic [29:0] corr_prod;
  logic [29:0] ra;
  logic        bump;

  assign mag        = sample_q[15] ? 15'(-sample_q) : sample_q[14:0];
  assign amp127     = {amp_i, 7'd0} - {7'd0, amp_i};
  assign recip_prod = 48'(a_q) * 48'(mwdds_pkg::RecipMult);
  assign corr_prod  = 30'(qa0_q) * 30'(mwdds_pkg::AmpDiv);
  assign ra         = {1'b0, a_q} - corr_prod;
  assign bump       = (ra >= 30'(mwdds_pkg::AmpDiv));

  // Duty formation and clamp: a negative product with a remainder rounds
  // one step further down
  logic [8:0]        qt;
  logic signed [9:0] q_s;
  logic signed [9:0] dsum;

  assign qt   = {1'b0, qa_q} + 9'(nz_q & sign_q);
  assign q_s  = sign_q ? -signed'({1'b0, qt}) : signed'({1'b0, qt});
  assign dsum = signed'({2'b00, mwdds_pkg::DutyMid}) + q_s;

  always_comb begin
    if (cmd_i.out_mid) begin
      duty_d = mwdds_pkg::DutyMid;
    end else if (dsum < 0) begin
      duty_d = '0;
    end else if (dsum > signed'({2'b00, mwdds_pkg::DutyMax})) begin
      duty_d = mwdds_pkg::DutyMax;
    end else begin
      duty_d = dsum[7:0];
    end
  end

  assign pwm_duty_o = duty_q;

  // Control-carrying state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.mul) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CntBits'(1);
      end
      if (cmd_i.acc) begin
        phase_q <= phase_q + quot_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      elapsed_q <= elapsed_us_i;
    end
    if (cmd_i.mul) begin
      num_q  <= NumPadBits'({freq_prod, {(PHASE_BITS - 4){1'b0}}});
      rem_q  <= '0;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q  <= num_q << 4;
      rem_q  <= rem_v;
      quot_q <= {quot_q[PHASE_BITS-5:0], qbits};
    end
    if (cmd_i.wave) begin
      rom_q <= quarter_rom[rom_addr];
      neg_q <= quad[1];
      u_q   <= wave_prod[48:32];
    end
    if (cmd_i.samp) begin
      sample_q <= sample_d;
    end
    if (cmd_i.scale) begin
      sign_q <= sample_q[15];
      a_q    <= 29'(amp127) * 29'(mag);
    end
    if (cmd_i.recip) begin
      qa0_q <= recip_prod[mwdds_pkg::RecipShift +: 8];
    end
    if (cmd_i.corr) begin
      qa_q <= qa0_q + 8'(bump);
      nz_q <= bump ? (ra != 30'(mwdds_pkg::AmpDiv)) : (ra != '0);
    end
    if (cmd_i.out_load) begin
      duty_q <= duty_d;
    end
  end

endmodule

/* rtl/multi_waveform_dds_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_dds_generator_unit: multi-shape DDS with PWM duty output
// Phase accumulator advanced by elapsed microseconds, sine/square/triangle/
// sawtooth sample, amplitude scaling into an 8-bit PWM duty around 128.
// ----------------------------------------------------------------------------
//
//  channel  dir   payload                     beat taken when
//  -------  ----  --------------------------  ---------------------------
//  tick_i   in    elapsed_us [15:0]           tick_i.valid & tick_i.ready
//  duty_o   out   pwm_duty   [7:0]            duty_o.valid & duty_o.ready
//  cfg_i    in    idx [3:0], data [31:0]      cfg_i.valid (ready tied high)
//
//  Flow: one tick at a time. An enabled tick passes the multiply state, then
//  D = ceil((PHASE_BITS + 29) / 4) divider steps (16 at 32 bits), then the
//  accumulate, wave, sample, scale, reciprocal, correct and output states.
//  A disabled tick skips the arithmetic and returns the midpoint.
//  The phase divider retires four quotient bits a cycle.
//  Stalls: the result parks in the output register; the next tick is taken
//  meanwhile, and its result waits in the datapath until that register frees.
//  Reset: phase cleared, config registers to defaults, no clearing pass.
// ----------------------------------------------------------------------------
module multi_waveform_dds_generator_unit #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned PHASE_BITS         = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mwdds_in_if.sink           tick_i,
  mwdds_out_if.source        duty_o,
  mwdds_cfg_if.sink          cfg_i
);

  // Configuration registers
  logic                              enable_q;
  mwdds_pkg::wave_shape_e            shape_q;
  logic [mwdds_pkg::FreqBits-1:0]    freq_q;
  logic [mwdds_pkg::AmpBits-1:0]     amp_q;

  mwdds_pkg::mwdds_cmd_t             cmd;
  mwdds_pkg::mwdds_status_t          status;
  logic                              in_ready;
  logic                              out_valid;
  logic [mwdds_pkg::DutyBits-1:0]    duty;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      shape_q  <= mwdds_pkg::WaveSine;
      freq_q   <= mwdds_pkg::FreqReset;
      amp_q    <= mwdds_pkg::AmpReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        mwdds_pkg::CfgEnable: begin
          enable_q <= cfg_i.data[0];
        end
        mwdds_pkg::CfgWaveShape: begin
          shape_q <= mwdds_pkg::wave_shape_e'(cfg_i.data[1:0]);
        end
        mwdds_pkg::CfgFreq: begin
          freq_q <= cfg_i.data[mwdds_pkg::FreqBits-1:0];
        end
        mwdds_pkg::CfgAmplitude: begin
          amp_q <= cfg_i.data[mwdds_pkg::AmpBits-1:0];
        end
        default: begin
          // drop writes to unmapped indices
        end
      endcase
    end
  end

  // Sequencer: walks a tick through the datapath, owns the output valid
  mwdds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (duty_o.ready),
    .enable_i    (enable_q),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic: phase step divider, accumulator, shapes, duty scaling
  mwdds_datapath #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .PHASE_BITS         (PHASE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .elapsed_us_i (tick_i.elapsed_us),
    .freq_i       (freq_q),
    .shape_i      (shape_q),
    .amp_i        (amp_q),
    .pwm_duty_o   (duty)
  );

  assign tick_i.ready    = in_ready;
  assign duty_o.valid    = out_valid;
  assign duty_o.pwm_duty = duty;

endmodule

/* rtl/mwdds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwdds_checker: port-level assertions for the waveform synthesiser
// Tracks ticks in flight against duty beats delivered.
// ----------------------------------------------------------------------------
module mwdds_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_valid_i,
  input  logic                            tick_ready_i,
  input  logic                            duty_valid_i,
  input  logic                            duty_ready_i,
  input  logic [mwdds_pkg::DutyBits-1:0]  duty_i
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending_q, pending_d;

  assign in_beat  = tick_valid_i && tick_ready_i;
  assign out_beat = duty_valid_i && duty_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (in_beat && !out_beat) begin
      pending_d = pending_q + 2'd1;
    end else if (!in_beat && out_beat) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Hold a stalled duty beat
  a_duty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_valid_i && !duty_ready_i |=> duty_valid_i && $stable(duty_i))
    else $error("duty beat changed while stalled");

  // One tick at a time: no new tick right after one is taken
  a_tick_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !tick_ready_i)
    else $error("tick taken on consecutive cycles");

  // A duty beat only for a tick that was taken
  a_duty_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_valid_i |-> pending_q != 2'd0)
    else $error("duty beat without a tick");

  // At most one parked result and one in flight
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many ticks in flight");

endmodule

bind multi_waveform_dds_generator_unit mwdds_checker u_mwdds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tick_valid_i (tick_i.valid),
  .tick_ready_i (tick_i.ready),
  .duty_valid_i (duty_o.valid),
  .duty_ready_i (duty_o.ready),
  .duty_i       (duty_o.pwm_duty)
);

/* tb/mwdds_duty_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwdds_duty_checker: duty prediction and scoreboard for the DDS unit
// Tracks register writes and the phase accumulator, predicts the duty of
// each accepted tick and compares every duty beat with the oldest prediction.
// ----------------------------------------------------------------------------
module mwdds_duty_checker
  import mwdds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  mwdds_in_if         tick_i,
  mwdds_out_if        duty_i,
  mwdds_cfg_if        cfg_i,
  output int unsigned n_errors_o,
  output int unsigned n_pending_o
);

  localparam int unsigned     PhaseBits   = 32;
  localparam int unsigned     SineIdxBits = 10;   // 1024-entry table
  localparam int unsigned     QuarterLen  = 256;
  localparam longint unsigned HalfPiQ30   = 64'd1686629713;
  localparam longint unsigned TriSpan     = 64'd131068;
  localparam longint unsigned RampSpan    = 64'd65534;
  localparam int              Q15         = Q15Max;
  localparam longint          DutyScale   = 127;
  localparam longint          DutyDivisor = AmpDiv;
  localparam longint          DutyTop     = DutyMax;

  logic                 en;
  wave_shape_e          shape;
  logic [FreqBits-1:0]  freq;
  logic [AmpBits-1:0]   amp;
  logic [PhaseBits-1:0] phase;
  logic [DutyBits-1:0]  expected_duty [$];

  // Quarter-wave sine in Q1.15, odd Taylor series up to the x^13 term
  function automatic int quarter_sine(int unsigned m);
    longint unsigned x, x2, term, s;
    longint          sum;
    int unsigned     k;
    x    = (longint'(m) * HalfPiQ30) / QuarterLen;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else            sum += longint'(term);
    end
    if (sum < 0) return 0;
    s = (longint'(sum) * Q15 + (64'd1 << 29)) >> 30;
    return (s > Q15) ? Q15 : int'(s);
  endfunction

  function automatic int sine_sample(logic [SineIdxBits-1:0] idx);
    int unsigned m;
    int          v;
    m = idx[SineIdxBits-3:0];
    v = idx[SineIdxBits-2] ? quarter_sine(QuarterLen - m) : quarter_sine(m);
    return idx[SineIdxBits-1] ? -v : v;
  endfunction

  function automatic int wave_sample(logic [PhaseBits-1:0] ph);
    longint unsigned u;
    case (shape)
      WaveSine:   return sine_sample(ph[PhaseBits-1 -: SineIdxBits]);
      WaveSquare: return (ph != '0 && !ph[PhaseBits-1]) ? Q15 : -Q15;
      WaveTriangle: begin
        u = (longint'(ph) * TriSpan) >> 32;
        if (u < 32767) return int'(u);
        if (u < 98301) return 65534 - int'(u);
        return int'(u) - 131068;
      end
      default: begin
        u = (longint'(ph) * RampSpan) >> 32;
        return int'(u) - Q15;
      end
    endcase
  endfunction

  // Advance the phase by one tick and return the duty it produces
  function automatic logic [DutyBits-1:0] predict_duty(logic [ElapsedBits-1:0] elapsed);
    longint unsigned step;
    longint          num, quot, duty;
    if (!en) return DutyMid;
    step  = ((longint'(freq) * elapsed) << (PhaseBits - 4)) / UsPerSecond;
    phase = phase + step[PhaseBits-1:0];
    num   = DutyScale * longint'(amp) * longint'(wave_sample(phase));
    if (num >= 0) quot = num / DutyDivisor;
    else          quot = -((-num + DutyDivisor - 1) / DutyDivisor);
    duty = longint'(DutyMid) + quot;
    if (duty < 0)       duty = 0;
    if (duty > DutyTop) duty = DutyTop;
    return duty[DutyBits-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [DutyBits-1:0] want;
    if (!rst_ni) begin
      en         = 1'b1;
      shape      = WaveSine;
      freq       = FreqReset;
      amp        = AmpReset;
      phase      = '0;
      n_errors_o = 0;
      expected_duty.delete();
    end else begin
      // Check the duty beat first: it always belongs to an earlier tick
      if (duty_i.valid && duty_i.ready) begin
        if (expected_duty.size() == 0) begin
          $display("%0t: duty beat %0d with no tick outstanding", $time, duty_i.pwm_duty);
          n_errors_o++;
        end else begin
          want = expected_duty.pop_front();
          if (duty_i.pwm_duty !== want) begin
            $display("%0t: pwm_duty mismatch: expected %0d, actual %0d",
                     $time, want, duty_i.pwm_duty);
            n_errors_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.idx)
          CfgEnable:    en    = cfg_i.data[0];
          CfgWaveShape: shape = wave_shape_e'(cfg_i.data[1:0]);
          CfgFreq:      freq  = cfg_i.data[FreqBits-1:0];
          CfgAmplitude: amp   = cfg_i.data[AmpBits-1:0];
          default: ;
        endcase
      end
      if (tick_i.valid && tick_i.ready) begin
        expected_duty.push_back(predict_duty(tick_i.elapsed_us));
      end
    end
    n_pending_o = expected_duty.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the multi-waveform DDS unit
// Drives tick and register beats through directed corners and randomised
// segments under three idling profiles, with one long output hold-off; the
// checker beside the unit predicts and compares every duty beat.
// ----------------------------------------------------------------------------
module testbench;
  import mwdds_pkg::*;

  localparam int unsigned ResetCycles      = 6;
  localparam int unsigned HoldOffCycles    = 400;  // long output stall to back the unit up
  localparam int unsigned DrainCycles      = 40;   // extra wait after the drain for any stray result
  localparam int unsigned WatchdogLimit    = 4000;
  localparam int unsigned SegmentsPerPhase = 4;
  localparam int unsigned TicksPerSegment  = 54;

  // Register select masks for set_regs
  localparam logic [3:0] SelEnable = 4'b0001 << CfgEnable;
  localparam logic [3:0] SelShape  = 4'b0001 << CfgWaveShape;
  localparam logic [3:0] SelFreq   = 4'b0001 << CfgFreq;
  localparam logic [3:0] SelAmp    = 4'b0001 << CfgAmplitude;
  localparam logic [3:0] SelAll    = SelEnable | SelShape | SelFreq | SelAmp;

  logic        clk_i;
  logic        rst_ni;
  int unsigned n_errors;
  int unsigned n_pending;
  int unsigned n_sent       = 0;
  int unsigned n_taken      = 0;
  int unsigned send_gap_pct = 35;
  int unsigned take_gap_pct = 77;
  logic        hold_armed   = 1'b0;
  int unsigned stall_cycles = 0;

  mwdds_in_if  tick_if ();
  mwdds_out_if duty_if ();
  mwdds_cfg_if cfg_if ();

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  multi_waveform_dds_generator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_if),
    .duty_o (duty_if),
    .cfg_i  (cfg_if)
  );

  mwdds_duty_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_if),
    .duty_i      (duty_if),
    .cfg_i       (cfg_if),
    .n_errors_o  (n_errors),
    .n_pending_o (n_pending)
  );

  // Duty receiver: count beats, idle at the current rate, and once armed hold
  // ready low for a long stretch so the unit parks a result and stalls ticks.
  initial begin
    int unsigned held;
    held = 0;
    duty_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (duty_if.valid && duty_if.ready) n_taken++;
      if (hold_armed && held < HoldOffCycles) begin
        duty_if.ready <= 1'b0;
        held++;
      end else begin
        duty_if.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if ((tick_if.valid && tick_if.ready) || (duty_if.valid && duty_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one tick beat, idling first at the current rate. Leave valid high on
  // return: the caller either offers the next beat or drops valid in this step.
  task automatic send_tick(input logic [ElapsedBits-1:0] elapsed);
    while ($urandom_range(99) < send_gap_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid      <= 1'b1;
    tick_if.elapsed_us <= elapsed;
    do @(posedge clk_i); while (!tick_if.ready);
    n_sent++;
  endtask

  // Drop tick valid and hold until every duty beat has come back
  task automatic drain();
    tick_if.valid <= 1'b0;
    while (n_taken != n_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Write the selected registers once the unit is idle
  task automatic set_regs(input logic [3:0] sel, input logic en, input wave_shape_e shape,
                          input int unsigned freq, input int unsigned amp);
    drain();
    if (sel[CfgEnable])    write_reg(CfgEnable, 32'(en));
    if (sel[CfgWaveShape]) write_reg(CfgWaveShape, 32'(shape));
    if (sel[CfgFreq])      write_reg(CfgFreq, freq);
    if (sel[CfgAmplitude]) write_reg(CfgAmplitude, amp);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly nominal tick spacing, with full-range values and both extremes
  function automatic logic [ElapsedBits-1:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return ElapsedBits'($urandom_range(40, 10));
    if (r < 85) return ElapsedBits'($urandom_range(65535, 0));
    if (r < 90) return '0;
    if (r < 95) return '1;
    return ElapsedBits'($urandom_range(255, 0));
  endfunction

  // Legal band mostly, its edges, and any 17-bit value now and then
  function automatic int unsigned pick_freq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 320;
    if (r < 20) return 80000;
    if (r < 30) return $urandom_range(131071, 0);
    return $urandom_range(80000, 320);
  endfunction

  // Percent amplitude, its edges, and values above 100 that hit the clamp
  function automatic int unsigned pick_amp();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return 100;
    if (r < 30) return $urandom_range(127, 101);
    return $urandom_range(100, 0);
  endfunction

  initial begin
    int unsigned phase_no;
    int unsigned seg;
    int unsigned n;
    rst_ni             <= 1'b0;
    tick_if.valid      <= 1'b0;
    tick_if.elapsed_us <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.idx         <= '0;
    cfg_if.data        <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Square from a zero phase: zero itself and exactly half a cycle both
    // give the low level; 8000 x 1000 us advances by exactly 2^31.
    set_regs(SelShape | SelFreq, 1'b1, WaveSquare, 8000, 0);
    send_tick(0);
    send_tick(1000);
    send_tick(1000);
    send_tick(1);
    send_tick(500);

    // Sine at the lowest legal frequency with zero amplitude: midpoint only
    set_regs(SelShape | SelFreq | SelAmp, 1'b1, WaveSine, 320, 0);
    send_tick(25);
    send_tick(16'hFFFF);

    // Triangle at the widest frequency code, amplitude over 100 to clamp
    set_regs(SelShape | SelFreq | SelAmp, 1'b1, WaveTriangle, 17'h1FFFF, 127);
    send_tick(16'hFFFF);
    send_tick(12345);
    send_tick(25);
    send_tick(40000);

    // Sawtooth at the top legal frequency, full amplitude
    set_regs(SelShape | SelFreq | SelAmp, 1'b1, WaveSawtooth, 80000, 100);
    send_tick(0);
    send_tick(25);
    send_tick(7);
    send_tick(16'hFFFF);

    // Disabled: midpoint out, elapsed ignored, phase held
    set_regs(SelEnable, 1'b0, WaveSawtooth, 0, 0);
    send_tick(16'hFFFF);
    send_tick(0);
    send_tick(300);

    // Back on with a zero frequency: the phase must not move
    set_regs(SelEnable | SelShape | SelFreq, 1'b1, WaveSine, 0, 0);
    send_tick(100);
    send_tick(16'hFFFF);

    // Random segments under three idling profiles; the long output hold-off
    // comes at the start of the profile with no idling, so ticks keep coming.
    for (phase_no = 0; phase_no < 3; phase_no++) begin
      case (phase_no)
        0: begin
          send_gap_pct = 35;
          take_gap_pct = 77;
        end
        1: begin
          send_gap_pct = 77;
          take_gap_pct = 35;
        end
        default: begin
          send_gap_pct = 0;
          take_gap_pct = 0;
        end
      endcase
      for (seg = 0; seg < SegmentsPerPhase; seg++) begin
        set_regs(SelAll, ($urandom_range(9) != 0), wave_shape_e'(2'($urandom_range(3))),
                 pick_freq(), pick_amp());
        if (phase_no == 2 && seg == 0) hold_armed <= 1'b1;
        for (n = 0; n < TicksPerSegment; n++) send_tick(pick_elapsed());
      end
    end

    // Let the last beats return, then allow for any stray result
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mwdds_pkg.sv
rtl/mwdds_if.sv
rtl/mwdds_ctrl.sv
rtl/mwdds_datapath.sv
rtl/multi_waveform_dds_generator_unit.sv
rtl/mwdds_checker.sv
tb/mwdds_duty_checker.sv
tb/testbench.sv
